/* rtl/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and helper functions of the cloud texture shader.
// ----------------------------------------------------------------------------
package cts_pkg;

    // sum of sines
    localparam int OCTAVES          = 4;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int COORD_BITS       = 16;

    // register indexes
    localparam logic [7:0] CFG_THRESHOLD   = 8'd0;
    localparam logic [7:0] CFG_BLEND_RANGE = 8'd1;

    localparam logic [15:0] THRESHOLD_RESET   = 16'd22938;
    localparam logic [15:0] BLEND_RANGE_RESET = 16'd19661;

    localparam logic [15:0] WEIGHT_STEP = 16'd23167;
    localparam logic [15:0] GREY_RG     = 16'd20316;
    localparam logic [15:0] GREY_B      = 16'd51118;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sine table address width (entries 0..DEPTH)
    localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH + 1);

    // octave sum and product widths
    localparam int T_W    = $clog2(OCTAVES * 65536);
    localparam int PROD_W = 2 * T_W;
    localparam longint unsigned INTEN_DIV = 64'(2 * OCTAVES * OCTAVES) << 14;

    // translucency divider: quotient bits per stage
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = 16 / DIV_BPS;

    // pipeline stage map
    localparam int S_DIV0 = 9;
    localparam int S_TR   = S_DIV0 + DIV_STAGES;
    localparam int S_MUL  = S_TR + 1;
    localparam int NS     = S_MUL + 1;

    // side data that travels with a division
    typedef struct packed {
        logic [16:0] inten;
        logic        tr_one;
        logic        tr_zero;
    } t_div_side;

    // one table entry: degree-9 Taylor series in Q30, rounded to Q1.15
    function automatic logic [15:0] rom_entry(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return 16'(s);
    endfunction

    function automatic logic [(SINE_TABLE_DEPTH+1)*16-1:0] build_sine_rom();
        logic [(SINE_TABLE_DEPTH+1)*16-1:0] rom;
        rom = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k*16 +: 16] = rom_entry(k);
        end
        return rom;
    endfunction

    localparam logic [(SINE_TABLE_DEPTH+1)*16-1:0] SINE_ROM = build_sine_rom();

    // octave weight: 1, .707, .707^2, ... in Q1.15
    function automatic logic [15:0] octave_weight(int n);
        logic [31:0] w;
        w = 32'd32768;
        for (int i = 0; i < n; i++) begin
            w = (w * 32'(WEIGHT_STEP) + 32'd16384) >> 15;
        end
        return 16'(w);
    endfunction

    // coordinate times 2^lm cycles as a Q0.16 phase
    function automatic logic [15:0] coord_phase(logic [15:0] c, int lm);
        logic [63:0] v;
        int          sh;
        v  = 64'(c);
        sh = 16 + lm - COORD_BITS;
        if (sh >= 0) begin
            v = v << sh;
        end else begin
            v = v >> (-sh);
        end
        return v[15:0];
    endfunction

    // quarter turn times a Q1.15 sine, as a phase
    function automatic logic [15:0] quarter_offset(logic signed [15:0] s);
        logic [15:0] b;
        b = {~s[15], s[14:0]};
        return 16'({1'b0, b[15:1]} + 16'hC000);
    endfunction

    // weighted term, rounded half away from zero, biased by one half
    function automatic logic [15:0] weighted_term(logic [15:0] w, logic signed [15:0] s);
        logic [15:0] mag;
        logic [31:0] prod;
        logic [15:0] r;
        mag  = s[15] ? 16'(-s) : 16'(s);
        prod = 32'(mag) * 32'(w);
        r    = 16'((prod + 32'd16384) >> 15);
        return s[15] ? 16'(32'd32768 - 32'(r)) : 16'(32'd32768 + 32'(r));
    endfunction

endpackage

/* rtl/cts_sine.sv */
// ----------------------------------------------------------------------------
// cts_sine
// Two-stage sine lookup: quadrant fold and address, then table read and sign.
// ----------------------------------------------------------------------------
module cts_sine
    import cts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en_addr,
    input  logic               i_en_data,
    input  logic [15:0]        i_phase,
    output logic signed [15:0] o_sin
);

    logic [13+SIN_AW:0] w_scaled;
    logic [SIN_AW-1:0]  w_idx;
    logic [SIN_AW-1:0]  n_addr;
    logic [SIN_AW-1:0]  r_addr;
    logic               r_neg;
    logic [15:0]        w_mag;
    logic signed [15:0] r_sin;

    // fold the quadrant into a table index
    always_comb begin
        w_scaled = (14+SIN_AW)'(i_phase[13:0]) * (14+SIN_AW)'(SINE_TABLE_DEPTH);
        w_idx    = w_scaled[13+SIN_AW:14];
        n_addr   = i_phase[14] ? SIN_AW'(SIN_AW'(SINE_TABLE_DEPTH) - w_idx) : w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_addr) begin
            r_addr <= n_addr;
            r_neg  <= i_phase[15];
        end
    end

    // table read, negate in the upper half turn
    assign w_mag = SINE_ROM[r_addr*16 +: 16];

    always_ff @(posedge i_clk) begin
        if (i_en_data) begin
            r_sin <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_sin = r_sin;

endmodule

/* rtl/cts_div.sv */
// ----------------------------------------------------------------------------
// cts_div
// Pipelined restoring divider for the translucency quotient.
// ----------------------------------------------------------------------------
module cts_div
    import cts_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [15:0]           i_divisor,
    input  logic [15:0]           i_rem,
    input  logic [15:0]           i_low,
    input  t_div_side             i_side,
    output logic [15:0]           o_quot,
    output t_div_side             o_side
);

    logic [15:0] r_rem  [DIV_STAGES];
    logic [15:0] r_low  [DIV_STAGES];
    logic [15:0] r_quot [DIV_STAGES];
    t_div_side   r_side [DIV_STAGES];
    logic [15:0] n_rem  [DIV_STAGES];
    logic [15:0] n_low  [DIV_STAGES];
    logic [15:0] n_quot [DIV_STAGES];
    logic [15:0] w_rem_in  [DIV_STAGES];
    logic [15:0] w_low_in  [DIV_STAGES];
    logic [15:0] w_quot_in [DIV_STAGES];
    t_div_side   w_side_in [DIV_STAGES];

    // stage inputs: the first stage takes the ports, the rest the stage before
    always_comb begin
        w_rem_in[0]  = i_rem;
        w_low_in[0]  = i_low;
        w_quot_in[0] = 16'd0;
        w_side_in[0] = i_side;
        for (int s = 1; s < DIV_STAGES; s++) begin
            w_rem_in[s]  = r_rem[s-1];
            w_low_in[s]  = r_low[s-1];
            w_quot_in[s] = r_quot[s-1];
            w_side_in[s] = r_side[s-1];
        end
    end

    // DIV_BPS (4) quotient bits per stage
    always_comb begin
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] quot;
        logic [16:0] acc;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem  = w_rem_in[s];
            low  = w_low_in[s];
            quot = w_quot_in[s];
            for (int j = 0; j < DIV_BPS; j++) begin
                acc = {rem, low[15]};
                low = {low[14:0], 1'b0};
                if (acc >= {1'b0, i_divisor}) begin
                    acc  = acc - {1'b0, i_divisor};
                    quot = {quot[14:0], 1'b1};
                end else begin
                    quot = {quot[14:0], 1'b0};
                end
                rem = acc[15:0];
            end
            n_rem[s]  = rem;
            n_low[s]  = low;
            n_quot[s] = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_low[s]  <= n_low[s];
                r_quot[s] <= n_quot[s];
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

/* rtl/cloud_texture_shader_top.sv */
// ----------------------------------------------------------------------------
// cloud_texture_shader_top
// Takes one surface point per clock and returns one sky colour per item
// while the output is not stalled. The pipeline is 15 stages deep (two sine
// lookups, weighting, octave sum, product, intensity, a 4-stage divider and
// a select stage for translucency, blend products, rounding). Each stage
// holds its own valid bit and moves whenever the stage after it can take its
// item, so a stalled output is filled up behind before the input backs up.
// threshold and blend_range are to be written through the configuration
// channel (always ready) only while no item is in flight, unchecked by the block.
// ----------------------------------------------------------------------------
module cloud_texture_shader_top
    import cts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_coord_u,
    input  logic [15:0] i_coord_v,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);

    logic [15:0] r_threshold;
    logic [15:0] r_blend_range;

    logic [NS:1]   r_vld;
    logic [NS+1:1] w_en;

    logic [15:0] r_u1, r_v1, r_u2, r_v2;
    logic signed [15:0] w_s_pu [OCTAVES];
    logic signed [15:0] w_s_pv [OCTAVES];
    logic signed [15:0] w_s_t1 [OCTAVES];
    logic signed [15:0] w_s_t2 [OCTAVES];
    logic [15:0] w_ph1 [OCTAVES];
    logic [15:0] w_ph2 [OCTAVES];
    logic [15:0] r_term1 [OCTAVES];
    logic [15:0] r_term2 [OCTAVES];
    logic [T_W-1:0]    n_t1, n_t2, r_t1, r_t2;
    logic [PROD_W-1:0] r_prod;

    logic [PROD_W-1:0] w_inten_raw;
    logic [16:0]       w_inten;
    logic [16:0]       w_diff;
    logic [15:0]       r_rem0;
    logic [15:0]       r_low0;
    t_div_side         n_side0, r_side0;

    logic [15:0] w_quot;
    t_div_side   w_side;
    logic [16:0] r_tr;
    logic [16:0] r_inten;
    logic [33:0] r_pa;
    logic [32:0] r_prg;
    logic [32:0] r_pb;
    logic [15:0] r_red, r_green, r_blue;

    // round a blend sum to Q0.16 and saturate
    function automatic logic [15:0] sat16(logic [34:0] v);
        logic [34:0] r;
        r = (v + 35'd32768) >> 16;
        return (r > 35'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RESET;
            r_blend_range <= BLEND_RANGE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                CFG_BLEND_RANGE: r_blend_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[NS+1] = i_out_ready;
        for (int k = NS; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // coordinates ride along to the second lookup
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_u1 <= i_coord_u;
            r_v1 <= i_coord_v;
        end
        if (w_en[2]) begin
            r_u2 <= r_u1;
            r_v2 <= r_v1;
        end
    end

    // stages 1-4: phase offsets, then perturbed sines
    for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
        cts_sine u_sin_pu (
            .i_clk     (i_clk),
            .i_en_addr (w_en[1]),
            .i_en_data (w_en[2]),
            .i_phase   (coord_phase(i_coord_v, i - 1)),
            .o_sin     (w_s_pu[i])
        );
        cts_sine u_sin_pv (
            .i_clk     (i_clk),
            .i_en_addr (w_en[1]),
            .i_en_data (w_en[2]),
            .i_phase   (coord_phase(i_coord_u, i)),
            .o_sin     (w_s_pv[i])
        );

        assign w_ph1[i] = 16'(coord_phase(r_u2, i + 1) + quarter_offset(w_s_pu[i]));
        assign w_ph2[i] = 16'(coord_phase(r_v2, i) + quarter_offset(w_s_pv[i]));

        cts_sine u_sin_t1 (
            .i_clk     (i_clk),
            .i_en_addr (w_en[3]),
            .i_en_data (w_en[4]),
            .i_phase   (w_ph1[i]),
            .o_sin     (w_s_t1[i])
        );
        cts_sine u_sin_t2 (
            .i_clk     (i_clk),
            .i_en_addr (w_en[3]),
            .i_en_data (w_en[4]),
            .i_phase   (w_ph2[i]),
            .o_sin     (w_s_t2[i])
        );

        // stage 5: weighted terms
        always_ff @(posedge i_clk) begin
            if (w_en[5]) begin
                r_term1[i] <= weighted_term(octave_weight(i), w_s_t1[i]);
                r_term2[i] <= weighted_term(octave_weight(i), w_s_t2[i]);
            end
        end
    end

    // stage 6: octave sums
    always_comb begin
        n_t1 = '0;
        n_t2 = '0;
        for (int i = 0; i < OCTAVES; i++) begin
            n_t1 = n_t1 + T_W'(r_term1[i]);
            n_t2 = n_t2 + T_W'(r_term2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_t1 <= n_t1;
            r_t2 <= n_t2;
        end
        // stage 7: product
        if (w_en[7]) begin
            r_prod <= PROD_W'(r_t1) * PROD_W'(r_t2);
        end
    end

    // stage 8: intensity, threshold and saturation checks
    always_comb begin
        w_inten_raw = PROD_W'((64'(r_prod) + INTEN_DIV / 2) / INTEN_DIV);
        w_inten     = (w_inten_raw > PROD_W'(65536)) ? 17'd65536 : 17'(w_inten_raw);
        w_diff      = 17'(w_inten - 17'(r_threshold));
        n_side0.inten   = w_inten;
        n_side0.tr_one  = (w_inten <= 17'(r_threshold));
        n_side0.tr_zero = (w_diff >= 17'(r_blend_range));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_side0 <= n_side0;
            r_rem0  <= w_diff[15:0];
            r_low0  <= {1'b0, r_blend_range[15:1]};
        end
    end

    // translucency quotient
    cts_div u_div (
        .i_clk     (i_clk),
        .i_en      (w_en[S_TR-1:S_DIV0]),
        .i_divisor (r_blend_range),
        .i_rem     (r_rem0),
        .i_low     (r_low0),
        .i_side    (r_side0),
        .o_quot    (w_quot),
        .o_side    (w_side)
    );

    always_ff @(posedge i_clk) begin
        // translucency
        if (w_en[S_TR]) begin
            r_inten <= w_side.inten;
            if (w_side.tr_one) begin
                r_tr <= 17'd65536;
            end else if (w_side.tr_zero) begin
                r_tr <= 17'd0;
            end else begin
                r_tr <= 17'(17'd65536 - 17'(w_quot));
            end
        end
        // blend products
        if (w_en[S_MUL]) begin
            r_pa  <= 34'(17'(17'd65536 - r_tr)) * 34'(r_inten);
            r_prg <= 33'(r_tr) * 33'(GREY_RG);
            r_pb  <= 33'(r_tr) * 33'(GREY_B);
        end
        // round and saturate
        if (w_en[NS]) begin
            r_red   <= sat16(35'(r_pa) + 35'(r_prg));
            r_green <= sat16(35'(r_pa) + 35'(r_prg));
            r_blue  <= sat16(35'(r_pa) + 35'(r_pb));
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted item missing from first stage");

    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    a_grey_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red == o_green))
        else $error("red and green differ");

endmodule

/* tb/sv/cloud_shader_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloud_shader_checker
// Watches the config, input and output channels of the cloud texture shader,
// computes the expected sky colour of each accepted point and compares the
// results in order. Reports the number of failures to the testbench top.
// ----------------------------------------------------------------------------
module cloud_shader_checker
    import cts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_coord_u,
    input  logic [15:0] i_coord_v,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    input  logic        i_done,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_colors_seen
);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_color;

    t_color      color_queue[$];
    logic [15:0] sine_lut[0:SINE_TABLE_DEPTH];
    logic [15:0] thresh_reg;
    logic [15:0] range_reg;
    logic        done_seen;

    // quarter-wave table, Taylor series in Q30
    initial begin
        longint unsigned x, x2, t, s;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x  = (64'(k) * 64'd1686629713) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824 - x2 / 72;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
            s  = (((x * t) >> 30) + 64'd16384) >> 15;
            sine_lut[k] = (s > 64'd32767) ? 16'd32767 : 16'(s);
        end
    end

    function automatic int sine_of(logic [15:0] ph);
        int unsigned idx;
        int          mag;
        idx = (int'(ph[13:0]) * SINE_TABLE_DEPTH) >> 14;
        if (ph[14]) idx = SINE_TABLE_DEPTH - idx;
        mag = int'(sine_lut[idx]);
        return ph[15] ? -mag : mag;
    endfunction

    function automatic logic [15:0] phase_of(logic [15:0] c, int lm);
        logic [47:0] v;
        int          sh;
        v  = 48'(c);
        sh = 16 + lm - COORD_BITS;
        v  = (sh >= 0) ? (v << sh) : (v >> (-sh));
        return v[15:0];
    endfunction

    function automatic logic [15:0] perturb(int s);
        return 16'(((s + 32768) >> 1) + 32'hC000);
    endfunction

    function automatic int unsigned biased_term(int unsigned w, int s);
        int unsigned mag, r;
        mag = (s < 0) ? -s : s;
        r   = int'((64'(mag) * w + 64'd16384) >> 15);
        return (s < 0) ? 32768 - r : 32768 + r;
    endfunction

    function automatic logic [15:0] mix(longint unsigned tr, longint unsigned inten,
                                        longint unsigned grey);
        longint unsigned v;
        v = ((65536 - tr) * inten + tr * grey + 32768) >> 16;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic t_color sky_color(logic [15:0] u, logic [15:0] v);
        logic [15:0]     pu, pv, au, av;
        int unsigned     w, t1, t2;
        longint unsigned prod, dvs, inten, tr, q;
        t_color          c;
        pu = perturb(sine_of(phase_of(v, -1)));
        pv = perturb(sine_of(phase_of(u, 0)));
        w  = 32768;
        t1 = 0;
        t2 = 0;
        for (int i = 0; i < OCTAVES; i++) begin
            au = phase_of(u, i + 1);
            av = phase_of(v, i);
            t1 += biased_term(w, sine_of(16'(au + pu)));
            t2 += biased_term(w, sine_of(16'(av + pv)));
            pu = perturb(sine_of(av));
            pv = perturb(sine_of(au));
            w  = (w * 23167 + 16384) >> 15;
        end
        prod  = 64'(t1) * 64'(t2);
        dvs   = 64'(2 * OCTAVES * OCTAVES) << 14;
        inten = (prod + dvs / 2) / dvs;
        if (inten > 65536) inten = 65536;
        // translucency: full below threshold, ramps to zero over the range
        if (inten <= thresh_reg) begin
            tr = 65536;
        end else if (range_reg == 0) begin
            tr = 0;
        end else begin
            q  = (((inten - thresh_reg) << 16) + range_reg / 2) / range_reg;
            tr = (q >= 65536) ? 0 : 65536 - q;
        end
        c.red   = mix(tr, inten, 20316);
        c.green = c.red;
        c.blue  = mix(tr, inten, 51118);
        return c;
    endfunction

    // track registers, predict on input, compare on output, check leftovers
    always @(posedge i_clk) begin
        t_color want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            thresh_reg    <= THRESHOLD_RESET;
            range_reg     <= BLEND_RANGE_RESET;
            o_fail_count  <= 0;
            o_colors_seen <= 0;
            o_pending     <= 0;
            done_seen     <= 1'b0;
            color_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_THRESHOLD) thresh_reg <= i_cfg_data;
                else if (i_cfg_index == CFG_BLEND_RANGE) range_reg <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                color_queue.push_back(sky_color(i_coord_u, i_coord_v));
            if (i_out_valid && i_out_ready) begin
                o_colors_seen <= o_colors_seen + 1;
                if (color_queue.size() == 0) begin
                    $error("color item with none expected");
                    errs++;
                end else begin
                    want = color_queue.pop_front();
                    if (want.red !== i_red || want.green !== i_green
                            || want.blue !== i_blue) begin
                        if (want.red !== i_red)
                            $error("red: expected %0d, got %0d", want.red, i_red);
                        if (want.green !== i_green)
                            $error("green: expected %0d, got %0d", want.green, i_green);
                        if (want.blue !== i_blue)
                            $error("blue: expected %0d, got %0d", want.blue, i_blue);
                        errs++;
                    end
                end
            end
            // leftover expectations at the end
            if (i_done && !done_seen) begin
                done_seen <= 1'b1;
                if (color_queue.size() != 0) begin
                    $error("%0d colors never arrived", color_queue.size());
                    errs++;
                end
            end
            o_pending    <= color_queue.size();
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cloud texture shader: directed corner points, then random
// points under several threshold and blend range settings, with random
// stalls on both channels, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb
    import cts_pkg::*;
;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_coord_u;
    logic [15:0] i_coord_v;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_red;
    logic [15:0] o_green;
    logic [15:0] o_blue;
    logic        run_done;
    int          fail_count;
    int          pending;
    int          colors_seen;
    int          points_sent;
    bit          calm;
    bit          hold_req;
    bit          hold_ack;
    int          holdoff_left;

    cloud_texture_shader_top i_dut (.*);

    cloud_shader_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_coord_u, .i_coord_v,
        .i_out_valid(o_out_valid), .i_out_ready, .i_red(o_red), .i_green(o_green),
        .i_blue(o_blue), .i_done(run_done), .o_fail_count(fail_count),
        .o_pending(pending), .o_colors_seen(colors_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls, a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            i_out_ready  <= 1'b0;
            holdoff_left <= 200;
        end else if (holdoff_left > 0) begin
            i_out_ready  <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // valid stays up after an accept so points can follow back to back
    task automatic send_point(logic [15:0] u, logic [15:0] v);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coord_u  <= u;
        i_coord_v  <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        points_sent++;
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_points(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: send_point(16'($urandom_range(3)) * 16'h5555, 16'($urandom));
                default: send_point(16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [15:0] corner [6];
        corner       = '{16'h0000, 16'h0001, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_coord_u    = '0;
        i_coord_v    = '0;
        run_done     = 1'b0;
        calm         = 1'b0;
        points_sent  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // corner points with reset registers
        for (int a = 0; a < 6; a++)
            for (int b = 0; b < 4; b++)
                send_point(corner[a], corner[b + 2]);
        drain_pipe();

        // settings: extremes, zero range, sharp edge, and an ignored index
        write_reg(8'd2, 16'h1234);
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_BLEND_RANGE, 16'd0);
        random_points(200);
        drain_pipe();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_BLEND_RANGE, 16'hFFFF);
        random_points(200);
        drain_pipe();
        write_reg(CFG_THRESHOLD, 16'd20000);
        write_reg(CFG_BLEND_RANGE, 16'd1);
        random_points(200);
        drain_pipe();

        // long output hold-off while points keep coming
        hold_req = ~hold_req;
        random_points(100);
        drain_pipe();

        // stretch with no idling at all
        write_reg(CFG_THRESHOLD, THRESHOLD_RESET);
        write_reg(CFG_BLEND_RANGE, BLEND_RANGE_RESET);
        calm = 1'b1;
        random_points(300);
        calm = 1'b0;
        drain_pipe();

        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_THRESHOLD, 16'($urandom));
            write_reg(CFG_BLEND_RANGE, 16'($urandom));
            random_points(110);
            drain_pipe();
        end

        run_done = 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        $display("Covered %0d points, %0d colors, across several register settings",
                 points_sent, colors_seen);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
